// ===== rtl/core/rrsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsp_pkg - reply stream parser shared definitions
// Character codes, event kinds, stack sizing and controller/datapath links.
// ----------------------------------------------------------------------------
package rrsp_pkg;

	localparam int MAX_DEPTH = 8;
	localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [3:0] EV_SIMPLE   = 4'd0;
	localparam logic [3:0] EV_ERROR    = 4'd1;
	localparam logic [3:0] EV_INTEGER  = 4'd2;
	localparam logic [3:0] EV_BULK     = 4'd3;
	localparam logic [3:0] EV_NIL      = 4'd4;
	localparam logic [3:0] EV_UNKNOWN  = 4'd5;
	localparam logic [3:0] EV_ELEM_END = 4'd6;
	localparam logic [3:0] EV_BAD_LEN  = 4'd7;
	localparam logic [3:0] EV_OVERFLOW = 4'd8;
	localparam logic [3:0] EV_CLOSED   = 4'd9;

	localparam logic [1:0] LK_SIMPLE  = 2'd0;
	localparam logic [1:0] LK_ERROR   = 2'd1;
	localparam logic [1:0] LK_INTEGER = 2'd2;
	localparam logic [1:0] LK_BULKLEN = 2'd0;
	localparam logic [1:0] LK_ARRLEN  = 2'd1;

	localparam logic [35:0] MAG_CAP     = 36'd2147483649;
	localparam logic [31:0] INT_POS_MAX = 32'd2147483647;

	localparam logic [31:0] RESET_MAX_BULK = 32'd536870912;

	typedef enum logic [2:0] {
		LEN_MALFORMED,
		LEN_NIL,
		LEN_BULK_ZERO,
		LEN_BULK,
		LEN_ARR_EMPTY,
		LEN_OVERFLOW,
		LEN_PUSH
	} len_eval_t;

	typedef struct packed {
		logic clear;
		logic len_start;
		logic len_byte;
		logic bulk_load;
		logic bulk_dec;
		logic push;
		logic finish;
		logic is_array;
	} dp_cmd_t;

	typedef struct packed {
		len_eval_t len_eval;
		logic      bulk_last;
		logic      sep;
		logic      done;
	} dp_sts_t;

endpackage

// ===== rtl/core/rrsp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsp_dp - reply parser datapath
// Length accumulator, bulk counter, array count stack and bulk limit register.
// ----------------------------------------------------------------------------
module rrsp_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          data_byte,
	input  logic                cfg_valid,
	input  logic [30:0]         max_bulk_length,
	input  rrsp_pkg::dp_cmd_t   cmd,
	output rrsp_pkg::dp_sts_t   sts
);

	logic [30:0]                       max_bulk_q;
	logic [31:0]                       len_q;
	logic                              neg_q;
	logic                              seen_q;
	logic                              stopped_q;
	logic                              arr_q;
	logic [30:0]                       bulk_q;
	logic [rrsp_pkg::LVL_W-1:0]        level_q;
	logic [30:0]                       rem_q [rrsp_pkg::MAX_DEPTH];
	logic [rrsp_pkg::MAX_DEPTH-1:0]    one_q;
	logic [rrsp_pkg::MAX_DEPTH-1:0]    two_q;

	logic                              is_digit;
	logic [35:0]                       prod;
	logic [31:0]                       len_next;
	logic                              found;
	logic [rrsp_pkg::IDX_W-1:0]        fidx;
	logic [rrsp_pkg::IDX_W-1:0]        push_idx;

	assign is_digit = (data_byte >= rrsp_pkg::CH_ZERO) && (data_byte <= rrsp_pkg::CH_NINE);
	assign prod     = {1'b0, len_q, 3'b000} + {3'b000, len_q, 1'b0}
	                  + {32'd0, data_byte[3:0] - rrsp_pkg::CH_ZERO[3:0]};
	assign len_next = (prod > rrsp_pkg::MAG_CAP) ? rrsp_pkg::MAG_CAP[31:0] : prod[31:0];
	assign push_idx = level_q[rrsp_pkg::IDX_W-1:0];

	// topmost open level that does not close with this element
	always_comb begin
		found = 1'b0;
		fidx  = '0;
		for (int i = 0; i < rrsp_pkg::MAX_DEPTH; i++) begin
			if ((rrsp_pkg::LVL_W'(i) < level_q) && !one_q[i]) begin
				found = 1'b1;
				fidx  = rrsp_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		logic neg;
		neg = neg_q && (len_q != 32'd0);
		sts.bulk_last = (bulk_q == 31'd1);
		sts.sep       = found;
		sts.done      = !found;
		if (!seen_q) begin
			sts.len_eval = rrsp_pkg::LEN_MALFORMED;
		end else if (neg) begin
			sts.len_eval = (len_q == 32'd1) ? rrsp_pkg::LEN_NIL : rrsp_pkg::LEN_MALFORMED;
		end else if (len_q > rrsp_pkg::INT_POS_MAX) begin
			sts.len_eval = rrsp_pkg::LEN_MALFORMED;
		end else if (!arr_q) begin
			if (len_q > {1'b0, max_bulk_q})
				sts.len_eval = rrsp_pkg::LEN_MALFORMED;
			else if (len_q == 32'd0)
				sts.len_eval = rrsp_pkg::LEN_BULK_ZERO;
			else
				sts.len_eval = rrsp_pkg::LEN_BULK;
		end else if (len_q == 32'd0) begin
			sts.len_eval = rrsp_pkg::LEN_ARR_EMPTY;
		end else if (level_q >= rrsp_pkg::LVL_W'(rrsp_pkg::MAX_DEPTH)) begin
			sts.len_eval = rrsp_pkg::LEN_OVERFLOW;
		end else begin
			sts.len_eval = rrsp_pkg::LEN_PUSH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bulk_q <= rrsp_pkg::RESET_MAX_BULK[30:0];
		end else if (cfg_valid) begin
			max_bulk_q <= max_bulk_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			neg_q     <= 1'b0;
			seen_q    <= 1'b0;
			stopped_q <= 1'b0;
			arr_q     <= 1'b0;
			bulk_q    <= '0;
			level_q   <= '0;
		end else if (cmd.clear) begin
			len_q     <= '0;
			neg_q     <= 1'b0;
			seen_q    <= 1'b0;
			stopped_q <= 1'b0;
			arr_q     <= 1'b0;
			bulk_q    <= '0;
			level_q   <= '0;
		end else begin
			if (cmd.len_start) begin
				len_q     <= '0;
				neg_q     <= 1'b0;
				seen_q    <= 1'b0;
				stopped_q <= 1'b0;
				arr_q     <= cmd.is_array;
			end else if (cmd.len_byte && !stopped_q) begin
				if (is_digit) begin
					len_q  <= len_next;
					seen_q <= 1'b1;
				end else if (!seen_q && !neg_q && data_byte == rrsp_pkg::CH_MINUS) begin
					neg_q <= 1'b1;
				end else begin
					stopped_q <= 1'b1;
				end
			end
			if (cmd.bulk_load)
				bulk_q <= len_q[30:0];
			else if (cmd.bulk_dec)
				bulk_q <= bulk_q - 31'd1;
			if (cmd.push)
				level_q <= level_q + rrsp_pkg::LVL_W'(1);
			else if (cmd.finish)
				level_q <= found ? (rrsp_pkg::LVL_W'(fidx) + rrsp_pkg::LVL_W'(1)) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && !cmd.clear) begin
			rem_q[push_idx] <= len_q[30:0];
			one_q[push_idx] <= (len_q == 32'd1);
			two_q[push_idx] <= (len_q == 32'd2);
		end else if (cmd.finish && !cmd.clear && found) begin
			rem_q[fidx] <= rem_q[fidx] - 31'd1;
			one_q[fidx] <= two_q[fidx];
			two_q[fidx] <= (rem_q[fidx] == 31'd3);
		end
	end

endmodule

// ===== rtl/core/rrsp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsp_ctrl - reply parser controller
// Parse phase sequencing, datapath commands and the registered event output.
// ----------------------------------------------------------------------------
module rrsp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              stream_closed,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [3:0]        event_kind,
	output logic [7:0]        event_byte,
	output logic              separator_follows,
	output logic              reply_done,
	output rrsp_pkg::dp_cmd_t cmd,
	input  rrsp_pkg::dp_sts_t sts
);

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_TEXT,
		PH_TEXT_END,
		PH_LEN,
		PH_LEN_END,
		PH_BULK,
		PH_TRAIL1,
		PH_TRAIL2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [1:0]  kind_q, kind_d;
	logic        out_valid_q;
	logic [3:0]  ev_kind_q;
	logic [7:0]  ev_byte_q;
	logic        ev_sep_q;
	logic        ev_done_q;

	logic        in_fire;
	logic        emit;
	logic [3:0]  e_kind;
	logic [7:0]  e_byte;
	logic        e_sep;
	logic        e_done;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		cmd     = '0;
		emit    = 1'b0;
		e_kind  = rrsp_pkg::EV_ELEM_END;
		e_byte  = 8'd0;
		e_sep   = 1'b0;
		e_done  = 1'b0;
		if (in_fire) begin
			if (stream_closed) begin
				cmd.clear = 1'b1;
				phase_d   = PH_PREFIX;
				kind_d    = '0;
				emit      = 1'b1;
				e_kind    = rrsp_pkg::EV_CLOSED;
				e_done    = 1'b1;
			end else begin
				unique case (phase_q)
					PH_PREFIX: begin
						if (data_byte == rrsp_pkg::CH_PLUS) begin
							phase_d = PH_TEXT;
							kind_d  = rrsp_pkg::LK_SIMPLE;
						end else if (data_byte == rrsp_pkg::CH_MINUS) begin
							phase_d = PH_TEXT;
							kind_d  = rrsp_pkg::LK_ERROR;
						end else if (data_byte == rrsp_pkg::CH_COLON) begin
							phase_d = PH_TEXT;
							kind_d  = rrsp_pkg::LK_INTEGER;
						end else if (data_byte == rrsp_pkg::CH_DOLLAR) begin
							phase_d       = PH_LEN;
							kind_d        = rrsp_pkg::LK_BULKLEN;
							cmd.len_start = 1'b1;
						end else if (data_byte == rrsp_pkg::CH_STAR) begin
							phase_d       = PH_LEN;
							kind_d        = rrsp_pkg::LK_ARRLEN;
							cmd.len_start = 1'b1;
							cmd.is_array  = 1'b1;
						end else begin
							cmd.finish = 1'b1;
							emit       = 1'b1;
							e_kind     = rrsp_pkg::EV_UNKNOWN;
							e_byte     = data_byte;
							e_sep      = sts.sep;
							e_done     = sts.done;
						end
					end
					PH_TEXT: begin
						if (data_byte == rrsp_pkg::CH_CR) begin
							phase_d = PH_TEXT_END;
						end else begin
							emit   = 1'b1;
							e_kind = {2'b00, kind_q};
							e_byte = data_byte;
						end
					end
					PH_LEN: begin
						if (data_byte == rrsp_pkg::CH_CR)
							phase_d = PH_LEN_END;
						else
							cmd.len_byte = 1'b1;
					end
					PH_LEN_END: begin
						phase_d = PH_PREFIX;
						unique case (sts.len_eval)
							rrsp_pkg::LEN_NIL: begin
								cmd.finish = 1'b1;
								emit       = 1'b1;
								e_kind     = rrsp_pkg::EV_NIL;
								e_sep      = sts.sep;
								e_done     = sts.done;
							end
							rrsp_pkg::LEN_ARR_EMPTY: begin
								cmd.finish = 1'b1;
								emit       = 1'b1;
								e_kind     = rrsp_pkg::EV_ELEM_END;
								e_sep      = sts.sep;
								e_done     = sts.done;
							end
							rrsp_pkg::LEN_BULK_ZERO: begin
								phase_d = PH_TRAIL1;
							end
							rrsp_pkg::LEN_BULK: begin
								cmd.bulk_load = 1'b1;
								phase_d       = PH_BULK;
							end
							rrsp_pkg::LEN_PUSH: begin
								cmd.push = 1'b1;
							end
							rrsp_pkg::LEN_OVERFLOW: begin
								cmd.clear = 1'b1;
								kind_d    = '0;
								emit      = 1'b1;
								e_kind    = rrsp_pkg::EV_OVERFLOW;
								e_done    = 1'b1;
							end
							default: begin
								cmd.clear = 1'b1;
								kind_d    = '0;
								emit      = 1'b1;
								e_kind    = rrsp_pkg::EV_BAD_LEN;
								e_done    = 1'b1;
							end
						endcase
					end
					PH_BULK: begin
						cmd.bulk_dec = 1'b1;
						if (sts.bulk_last)
							phase_d = PH_TRAIL1;
						emit   = 1'b1;
						e_kind = rrsp_pkg::EV_BULK;
						e_byte = data_byte;
					end
					PH_TRAIL1: begin
						phase_d = PH_TRAIL2;
					end
					PH_TEXT_END, PH_TRAIL2: begin
						phase_d    = PH_PREFIX;
						cmd.finish = 1'b1;
						emit       = 1'b1;
						e_kind     = rrsp_pkg::EV_ELEM_END;
						e_sep      = sts.sep;
						e_done     = sts.done;
					end
					default: begin
						phase_d = PH_PREFIX;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PREFIX;
			kind_q      <= '0;
			out_valid_q <= 1'b0;
			ev_kind_q   <= '0;
			ev_byte_q   <= '0;
			ev_sep_q    <= 1'b0;
			ev_done_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			if (emit) begin
				out_valid_q <= 1'b1;
				ev_kind_q   <= e_kind;
				ev_byte_q   <= e_byte;
				ev_sep_q    <= e_sep;
				ev_done_q   <= e_done;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign event_kind        = ev_kind_q;
	assign event_byte        = ev_byte_q;
	assign separator_follows = ev_sep_q;
	assign reply_done        = ev_done_q;

endmodule

// ===== rtl/core/resp_reply_stream_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_reply_stream_parser_unit - reply byte stream parser
// Type dispatch, text/bulk byte events, length parsing and nested arrays.
// ----------------------------------------------------------------------------
// Takes one reply byte per word and returns at most one event word per byte.
// Each byte is handled as it is accepted: the controller steps its phase, the
// datapath updates the length, bulk count and array stack in the same cycle,
// and the event lands in an output register, so a byte is accepted every cycle
// while out_ready keeps the output register draining. Stack unwinding at an
// element end is one priority search over the open levels. An abort clears all
// parser state; no clearing pass follows reset.
// ----------------------------------------------------------------------------
module resp_reply_stream_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] max_bulk_length,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        stream_closed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  event_kind,
	output logic [7:0]  event_byte,
	output logic        separator_follows,
	output logic        reply_done
);

	rrsp_pkg::dp_cmd_t cmd;
	rrsp_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	rrsp_ctrl u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.data_byte         (data_byte),
		.stream_closed     (stream_closed),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.event_kind        (event_kind),
		.event_byte        (event_byte),
		.separator_follows (separator_follows),
		.reply_done        (reply_done),
		.cmd               (cmd),
		.sts               (sts)
	);

	rrsp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.data_byte       (data_byte),
		.cfg_valid       (cfg_valid),
		.max_bulk_length (max_bulk_length),
		.cmd             (cmd),
		.sts             (sts)
	);

endmodule

// ===== test/tb_resp_reply_stream_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_resp_reply_stream_parser_unit - reply stream parser testbench
// Feeds reply byte streams (text lines, bulk strings, nested arrays, nil,
// bad lengths, overflow and closed-connection aborts) through the in/out
// valid-ready ports under random stalls and a long output hold-off. A class
// tracks parser state, predicts every event word and checks output words.
// ----------------------------------------------------------------------------
module tb_resp_reply_stream_parser_unit;

	localparam logic [7:0]  CH_LF        = 8'h0A;
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned QUIET_CYCLES = 4;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned SEG_BYTES    = 140;

	typedef enum logic [2:0] {
		ST_TYPE, ST_LINE, ST_LINE_CR, ST_COUNT, ST_COUNT_CR, ST_PAYLOAD, ST_TAIL1, ST_TAIL2
	} parse_state_e;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] data;
		logic       sep;
		logic       done;
	} reply_event_t;

	typedef struct packed {
		logic [7:0] data;
		logic       closed;
	} in_word_t;

	class reply_scoreboard;
		logic [30:0]    bulk_limit;
		parse_state_e   state;
		logic [1:0]     line_sel;
		logic [31:0]    count_acc;
		bit             count_neg;
		bit             count_digits;
		bit             count_stopped;
		logic [30:0]    payload_left;
		logic [31:0]    open_left [rrsp_pkg::MAX_DEPTH];
		int unsigned    open_depth;
		reply_event_t   expected_events [$];
		int unsigned    errors;

		function new();
			bulk_limit = rrsp_pkg::RESET_MAX_BULK[30:0];
			errors = 0;
			clear();
		endfunction

		function void clear();
			state = ST_TYPE;
			line_sel = '0;
			count_acc = '0;
			count_neg = 0;
			count_digits = 0;
			count_stopped = 0;
			payload_left = '0;
			foreach (open_left[i]) open_left[i] = '0;
			open_depth = 0;
		endfunction

		function void push_event(logic [3:0] kind, logic [7:0] data, logic sep, logic done);
			expected_events.insert(expected_events.size(),
				reply_event_t'({kind, data, sep, done}));
		endfunction

		function void abort_reply(logic [3:0] kind);
			clear();
			push_event(kind, 8'h00, 1'b0, 1'b1);
		endfunction

		function void end_element(logic [3:0] kind, logic [7:0] data);
			logic sep;
			logic done;
			sep = 1'b0;
			done = 1'b1;
			while (open_depth > 0) begin
				open_left[open_depth - 1] = open_left[open_depth - 1] - 1;
				if (open_left[open_depth - 1] != 0) begin
					sep = 1'b1;
					done = 1'b0;
					break;
				end
				open_depth--;
			end
			state = ST_TYPE;
			push_event(kind, data, sep, done);
		endfunction

		function void open_count(logic [1:0] sel);
			state = ST_COUNT;
			line_sel = sel;
			count_acc = '0;
			count_neg = 0;
			count_digits = 0;
			count_stopped = 0;
		endfunction

		function void close_count();
			if (!count_digits) begin
				abort_reply(rrsp_pkg::EV_BAD_LEN);
			end else if (count_neg && count_acc != 0) begin
				if (count_acc == 1)
					end_element(rrsp_pkg::EV_NIL, 8'h00);
				else
					abort_reply(rrsp_pkg::EV_BAD_LEN);
			end else if (count_acc > rrsp_pkg::INT_POS_MAX) begin
				abort_reply(rrsp_pkg::EV_BAD_LEN);
			end else if (line_sel == rrsp_pkg::LK_BULKLEN) begin
				if (count_acc > {1'b0, bulk_limit}) begin
					abort_reply(rrsp_pkg::EV_BAD_LEN);
				end else begin
					payload_left = count_acc[30:0];
					state = (count_acc == 0) ? ST_TAIL1 : ST_PAYLOAD;
				end
			end else if (count_acc == 0) begin
				end_element(rrsp_pkg::EV_ELEM_END, 8'h00);
			end else if (open_depth >= rrsp_pkg::MAX_DEPTH) begin
				abort_reply(rrsp_pkg::EV_OVERFLOW);
			end else begin
				open_left[open_depth] = count_acc;
				open_depth++;
				state = ST_TYPE;
			end
		endfunction

		function void take_byte(logic [7:0] b, logic closed);
			logic [63:0] acc;
			if (closed) begin
				abort_reply(rrsp_pkg::EV_CLOSED);
			end else begin
				case (state)
					ST_TYPE: begin
						case (b)
							rrsp_pkg::CH_PLUS: begin
								state = ST_LINE;
								line_sel = rrsp_pkg::LK_SIMPLE;
							end
							rrsp_pkg::CH_MINUS: begin
								state = ST_LINE;
								line_sel = rrsp_pkg::LK_ERROR;
							end
							rrsp_pkg::CH_COLON: begin
								state = ST_LINE;
								line_sel = rrsp_pkg::LK_INTEGER;
							end
							rrsp_pkg::CH_DOLLAR: open_count(rrsp_pkg::LK_BULKLEN);
							rrsp_pkg::CH_STAR:   open_count(rrsp_pkg::LK_ARRLEN);
							default:             end_element(rrsp_pkg::EV_UNKNOWN, b);
						endcase
					end
					ST_LINE: begin
						if (b == rrsp_pkg::CH_CR)
							state = ST_LINE_CR;
						else
							push_event({2'b00, line_sel}, b, 1'b0, 1'b0);
					end
					ST_LINE_CR: end_element(rrsp_pkg::EV_ELEM_END, 8'h00);
					ST_COUNT: begin
						if (b == rrsp_pkg::CH_CR) begin
							state = ST_COUNT_CR;
						end else if (!count_stopped) begin
							if (b >= rrsp_pkg::CH_ZERO && b <= rrsp_pkg::CH_NINE) begin
								acc = {32'd0, count_acc} * 64'd10 + 64'(b - rrsp_pkg::CH_ZERO);
								count_acc = (acc > 64'(rrsp_pkg::MAG_CAP)) ?
									rrsp_pkg::MAG_CAP[31:0] : acc[31:0];
								count_digits = 1;
							end else if (!count_digits && !count_neg &&
									b == rrsp_pkg::CH_MINUS) begin
								count_neg = 1;
							end else begin
								count_stopped = 1;
							end
						end
					end
					ST_COUNT_CR: close_count();
					ST_PAYLOAD: begin
						payload_left = payload_left - 1;
						if (payload_left == 0)
							state = ST_TAIL1;
						push_event(rrsp_pkg::EV_BULK, b, 1'b0, 1'b0);
					end
					ST_TAIL1: state = ST_TAIL2;
					default: end_element(rrsp_pkg::EV_ELEM_END, 8'h00);
				endcase
			end
		endfunction

		function void check_event(logic [3:0] kind, logic [7:0] data, logic sep, logic done);
			reply_event_t want;
			if (expected_events.size() == 0) begin
				errors++;
				$display("%0t: unexpected event kind=%0d byte=%02h sep=%0b done=%0b",
					$time, kind, data, sep, done);
			end else begin
				want = expected_events.pop_front();
				if (want.kind !== kind || want.data !== data || want.sep !== sep ||
						want.done !== done) begin
					errors++;
					$display("%0t: event mismatch: expected kind=%0d byte=%02h sep=%0b done=%0b",
						$time, want.kind, want.data, want.sep, want.done);
					$display("%0t:                 actual kind=%0d byte=%02h sep=%0b done=%0b",
						$time, kind, data, sep, done);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_events.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [30:0] max_bulk_length;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        stream_closed;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  event_kind;
	logic [7:0]  event_byte;
	logic        separator_follows;
	logic        reply_done;

	reply_scoreboard sb;
	in_word_t        stim_q [$];
	logic [30:0]     cur_limit = rrsp_pkg::RESET_MAX_BULK[30:0];
	int unsigned     send_idle_pct;
	int unsigned     recv_idle_pct;
	int unsigned     hold_requests;
	int unsigned     cycle_count = 0;
	string           bad_counts [8] = '{"", "-", "--1", "-2", "x5", "2147483648",
		"99999999999999", "-2147483649"};

	resp_reply_stream_parser_unit i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.max_bulk_length   (max_bulk_length),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.data_byte         (data_byte),
		.stream_closed     (stream_closed),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.event_kind        (event_kind),
		.event_byte        (event_byte),
		.separator_follows (separator_follows),
		.reply_done        (reply_done)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.take_byte(data_byte, stream_closed);
			if (out_valid && out_ready)
				sb.check_event(event_kind, event_byte, separator_follows, reply_done);
		end
	end

	initial begin
		int unsigned served;
		int unsigned hold_left;
		served = 0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != served) begin
				served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic void add_byte(logic [7:0] b);
		stim_q.insert(stim_q.size(), in_word_t'({b, 1'b0}));
	endfunction

	function automatic void add_str(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	function automatic void add_closed();
		stim_q.insert(stim_q.size(), in_word_t'({8'($urandom_range(255)), 1'b1}));
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] v;
		do v = 8'($urandom_range(255)); while (v == rrsp_pkg::CH_CR);
		return v;
	endfunction

	function automatic void end_line();
		add_byte(rrsp_pkg::CH_CR);
		add_byte(($urandom_range(99) < 85) ? CH_LF : 8'($urandom_range(255)));
	endfunction

	function automatic void gen_bulk();
		int unsigned r;
		longint      n;
		logic [7:0]  junk;
		r = $urandom_range(9);
		if (r < 7)
			n = $urandom_range(0, 8);
		else if (r == 7)
			n = longint'(cur_limit);
		else if (r == 8)
			n = longint'(cur_limit) + 1;
		else
			n = $urandom_range(0, 3);
		add_byte(rrsp_pkg::CH_DOLLAR);
		if (r == 9)
			add_byte((n == 0 && $urandom_range(1)) ? rrsp_pkg::CH_MINUS : rrsp_pkg::CH_ZERO);
		add_str($sformatf("%0d", n));
		if (r == 9) begin
			do junk = text_byte();
			while (junk >= rrsp_pkg::CH_ZERO && junk <= rrsp_pkg::CH_NINE);
			add_byte(junk);
			repeat ($urandom_range(0, 2)) add_byte(text_byte());
		end
		end_line();
		if (n <= longint'(cur_limit)) begin
			if (n > 16) begin
				repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(255)));
				add_closed();
			end else begin
				repeat (n) add_byte(8'($urandom_range(255)));
				if ($urandom_range(99) < 80) begin
					add_byte(rrsp_pkg::CH_CR);
					add_byte(CH_LF);
				end else begin
					add_byte(8'($urandom_range(255)));
					add_byte(8'($urandom_range(255)));
				end
			end
		end
	endfunction

	function automatic void gen_leaf();
		int unsigned r;
		logic [7:0]  b;
		r = $urandom_range(99);
		if (r < 38) begin
			add_byte((r < 18) ? rrsp_pkg::CH_PLUS :
				(r < 28) ? rrsp_pkg::CH_MINUS : rrsp_pkg::CH_COLON);
			if (r >= 28 && r < 36)
				add_str($sformatf("%0d", $signed($urandom)));
			else
				repeat ($urandom_range(0, 6)) add_byte(text_byte());
			end_line();
		end else if (r < 66) begin
			gen_bulk();
		end else if (r < 72) begin
			add_byte($urandom_range(1) ? rrsp_pkg::CH_DOLLAR : rrsp_pkg::CH_STAR);
			add_str("-1");
			end_line();
		end else if (r < 78) begin
			do b = 8'($urandom_range(255));
			while (b == rrsp_pkg::CH_PLUS || b == rrsp_pkg::CH_MINUS ||
				b == rrsp_pkg::CH_COLON || b == rrsp_pkg::CH_DOLLAR ||
				b == rrsp_pkg::CH_STAR);
			add_byte(b);
		end else if (r < 88) begin
			add_byte($urandom_range(1) ? rrsp_pkg::CH_DOLLAR : rrsp_pkg::CH_STAR);
			add_str(bad_counts[$urandom_range(7)]);
			end_line();
		end else if (r < 93) begin
			add_byte(rrsp_pkg::CH_STAR);
			add_str("2147483647");
			end_line();
			repeat ($urandom_range(0, 2)) begin
				add_byte(rrsp_pkg::CH_PLUS);
				add_byte(text_byte());
				end_line();
			end
			add_closed();
		end else begin
			add_closed();
		end
	endfunction

	function automatic void gen_reply();
		int unsigned remaining [$];
		int unsigned cap;
		int unsigned n;
		int unsigned k;
		bit          finished;
		cap = ($urandom_range(9) == 0) ? $urandom_range(8, 9) : 3;
		do begin
			finished = 1;
			if (remaining.size() < cap && $urandom_range(99) < ((cap > 3) ? 90 : 25)) begin
				n = (cap > 3) ? 1 : $urandom_range(0, 3);
				add_byte(rrsp_pkg::CH_STAR);
				add_str($sformatf("%0d", n));
				end_line();
				if (n != 0) begin
					remaining.insert(remaining.size(), n);
					finished = 0;
				end
			end else begin
				gen_leaf();
			end
			if (finished) begin
				while (remaining.size() > 0) begin
					k = remaining.size() - 1;
					remaining[k] = remaining[k] - 1;
					if (remaining[k] != 0)
						break;
					void'(remaining.pop_back());
				end
			end
		end while (remaining.size() > 0);
	endfunction

	function automatic void build_segment(int unsigned target);
		int unsigned r;
		int unsigned base;
		int unsigned added;
		while (stim_q.size() < target) begin
			r = $urandom_range(99);
			if (r < 80) begin
				gen_reply();
			end else if (r < 90) begin
				repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(255)));
			end else begin
				base = stim_q.size();
				gen_reply();
				added = stim_q.size() - base;
				repeat ($urandom_range(0, added - 1)) void'(stim_q.pop_back());
				add_closed();
			end
		end
	endfunction

	task automatic send_stream();
		in_word_t w;
		while (stim_q.size() > 0) begin
			w = stim_q.pop_front();
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			in_valid <= 1'b1;
			data_byte <= w.data;
			stream_closed <= w.closed;
			do @(posedge clk); while (!in_ready);
			@(negedge clk);
		end
		in_valid <= 1'b0;
	endtask

	task automatic wait_quiet(int unsigned extra);
		while (sb.pending() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic set_bulk_limit(logic [30:0] v);
		max_bulk_length <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.bulk_limit = v;
		cur_limit = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(int unsigned s, int unsigned r);
		@(posedge clk);
		send_idle_pct = s;
		recv_idle_pct = r;
		@(negedge clk);
	endtask

	initial begin
		logic [30:0] limits [6];
		logic [7:0]  warmup [22];
		sb = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		max_bulk_length = '0;
		in_valid = 1'b0;
		data_byte = '0;
		stream_closed = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests = 0;
		limits = '{31'd0, 31'h7FFF_FFFF, 31'd3, 31'($urandom_range(1, 40)),
			31'($urandom_range(32'h7FFF_FFFF)), 31'd16};
		warmup = '{rrsp_pkg::CH_PLUS, 8'h00, 8'hFF, rrsp_pkg::CH_CR, CH_LF,
			rrsp_pkg::CH_STAR, "2", rrsp_pkg::CH_CR, CH_LF,
			rrsp_pkg::CH_DOLLAR, "1", rrsp_pkg::CH_CR, CH_LF, 8'h80, rrsp_pkg::CH_CR, CH_LF,
			rrsp_pkg::CH_STAR, rrsp_pkg::CH_MINUS, "1", rrsp_pkg::CH_CR, CH_LF, "?"};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (warmup[i]) add_byte(warmup[i]);
		add_closed();
		send_stream();

		for (int m = 0; m < 3; m++) begin
			set_idling((m == 0) ? 14 : (m == 1) ? 51 : 0, (m == 0) ? 51 : (m == 1) ? 14 : 0);
			for (int k = 0; k < 2; k++) begin
				wait_quiet(QUIET_CYCLES);
				set_bulk_limit(limits[2 * m + k]);
				if (m == 2 && k == 0) begin
					// receiver stalls long enough for the input side to back up
					@(posedge clk);
					hold_requests = hold_requests + 1;
					@(negedge clk);
				end
				build_segment(SEG_BYTES);
				send_stream();
			end
		end

		wait_quiet(DRAIN_CYCLES);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/rrsp_pkg.sv
rtl/core/rrsp_dp.sv
rtl/core/rrsp_ctrl.sv
rtl/core/resp_reply_stream_parser_unit.sv
test/tb_resp_reply_stream_parser_unit.sv
